FILE: sv/ucdc_pkg.sv
package ucdc_pkg;

  // Input event codes.
  typedef enum logic [2:0] {
    ACT_BUS_RESET     = 3'd0,
    ACT_SETUP         = 3'd1,
    ACT_EP0_IN_DONE   = 3'd2,
    ACT_EP0_OUT_DONE  = 3'd3,
    ACT_EP1_OUT       = 3'd4,
    ACT_OTHER_IN_DONE = 3'd5
  } action_e;

  // Result codes.
  typedef enum logic [2:0] {
    RK_NONE       = 3'd0,
    RK_DATA       = 3'd1,
    RK_ZLP        = 3'd2,
    RK_STALL_IN   = 3'd3,
    RK_STALL_BOTH = 3'd4,
    RK_ECHO       = 3'd5
  } reply_kind_e;

  // Work handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_QUIET   = 3'd1,
    OP_REPLY   = 3'd2,
    OP_START   = 3'd3,
    OP_IN_DONE = 3'd4,
    OP_ECHO    = 3'd5
  } cmd_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_op_e     op;
    reply_kind_e kind;
    logic [2:0]  src;
    logic [6:0]  arg;
    logic        set_addr;
    logic        set_cfg;
  } cmd_t;

  // Transfer sources.
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_DEVICE = 3'd1;
  localparam logic [2:0] SRC_CONFIG = 3'd2;
  localparam logic [2:0] SRC_LANG   = 3'd3;
  localparam logic [2:0] SRC_MFR    = 3'd4;
  localparam logic [2:0] SRC_PROD   = 3'd5;
  localparam logic [2:0] SRC_LINE   = 3'd6;

  // Request fields.
  localparam logic [7:0] RT_STD_IN_DEV   = 8'h80;
  localparam logic [7:0] RT_STD_OUT_DEV  = 8'h00;
  localparam logic [7:0] RT_STD_OUT_IF   = 8'h01;
  localparam logic [7:0] RT_CLASS_IN_IF  = 8'hA1;
  localparam logic [7:0] RT_CLASS_OUT_IF = 8'h21;
  localparam logic [7:0] RQ_GET_DESC     = 8'h06;
  localparam logic [7:0] RQ_SET_ADDRESS  = 8'h05;
  localparam logic [7:0] RQ_SET_CONFIG   = 8'h09;
  localparam logic [7:0] RQ_SET_IFACE    = 8'h0B;
  localparam logic [7:0] RQ_GET_LINE     = 8'h21;
  localparam logic [7:0] RQ_SET_LINE     = 8'h20;
  localparam logic [7:0] RQ_SET_CTRL     = 8'h22;
  localparam logic [7:0] DESC_DEVICE     = 8'h01;
  localparam logic [7:0] DESC_CONFIG     = 8'h02;
  localparam logic [7:0] DESC_STRING     = 8'h03;
  localparam logic [7:0] LAST_STRING     = 8'h02;

  localparam logic [9:0] ECHO_MAX = 10'd64;

  // Command queue geometry.
  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = 1;
  localparam int CmdCntW  = 2;

  localparam logic [7:0] RomDev [18] = '{
    8'd18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'd64, 8'hFE,
    8'hCA, 8'h01, 8'h40, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01
  };

  localparam logic [7:0] RomCfg [67] = '{
    8'd9, 8'h02, 8'd67, 8'd0, 8'd2, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'h04, 8'd0, 8'd0, 8'd1, 8'h02, 8'h02, 8'h01, 8'd0,
    8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
    8'd5, 8'h24, 8'h01, 8'h00, 8'h01,
    8'd4, 8'h24, 8'h02, 8'h02,
    8'd5, 8'h24, 8'h06, 8'h00, 8'h01,
    8'd7, 8'h05, 8'h82, 8'h03, 8'd8, 8'd0, 8'd255,
    8'd9, 8'h04, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'h00, 8'd0,
    8'd7, 8'h05, 8'h01, 8'h02, 8'd64, 8'd0, 8'd0,
    8'd7, 8'h05, 8'h81, 8'h02, 8'd64, 8'd0, 8'd0
  };

  localparam logic [7:0] RomLang [4] = '{8'd4, 8'h03, 8'h09, 8'h04};

  localparam logic [7:0] RomMfr [18] = '{
    8'd18, 8'h03, 8'h42, 8'h00, 8'h65, 8'h00, 8'h65, 8'h00, 8'h42,
    8'h00, 8'h6F, 8'h00, 8'h74, 8'h00, 8'h69, 8'h00, 8'h78, 8'h00
  };

  localparam logic [7:0] RomProd [18] = '{
    8'd18, 8'h03, 8'h42, 8'h00, 8'h50, 8'h00, 8'h43, 8'h00, 8'h44,
    8'h00, 8'h43, 8'h00, 8'h20, 8'h00, 8'h76, 8'h00, 8'h31, 8'h00
  };

  localparam logic [7:0] RomLine [7] = '{
    8'h80, 8'h25, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
  };

  function automatic logic [6:0] rom_len(input logic [2:0] src);
    logic [6:0] len;
    case (src)
      SRC_DEVICE: len = 7'd18;
      SRC_CONFIG: len = 7'd67;
      SRC_LANG:   len = 7'd4;
      SRC_MFR:    len = 7'd18;
      SRC_PROD:   len = 7'd18;
      SRC_LINE:   len = 7'd7;
      default:    len = 7'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] rom_byte(input logic [2:0] src, input logic [6:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (src)
      SRC_DEVICE: if (idx < 7'd18) b = RomDev[idx[4:0]];
      SRC_CONFIG: if (idx < 7'd67) b = RomCfg[idx];
      SRC_LANG:   if (idx < 7'd4)  b = RomLang[idx[1:0]];
      SRC_MFR:    if (idx < 7'd18) b = RomMfr[idx[4:0]];
      SRC_PROD:   if (idx < 7'd18) b = RomProd[idx[4:0]];
      SRC_LINE:   if (idx < 7'd7)  b = RomLine[idx[2:0]];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/usb_cdc_control_responder.sv
// USB CDC control-endpoint responder. Each transfer on the input side is one
// device event (bus reset, decoded SETUP, endpoint-0 IN or OUT completion,
// endpoint-1 OUT reception), and it produces one or more results on the
// output side, the final one flagged by last_of_run_o. Descriptor and
// line-coding replies come from a fixed ROM, trimmed to wLength and sent as
// chunks of MAX_PACKET bytes, one result per byte; the first chunk follows
// the SETUP and each later chunk follows an endpoint-0 IN completion. Every
// result carries the active device address and configured flag as they
// stand after its event. A chunk takes one step to set up the ROM walk and
// then one result per byte, each loaded only when the result register has
// room. A two-entry command queue lets new events be taken while a reply is
// still being sent, and a result register holds each result until it is
// popped; the next result can be loaded in the same cycle as the pop.
module usb_cdc_control_responder #(
  parameter int MAX_PACKET = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  input  logic [9:0]  received_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  reply_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_run_o,
  output logic [6:0]  echo_count_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o
);

  ucdc_pkg::cmd_t front_cmd;
  ucdc_pkg::cmd_t queue_cmd;
  logic           queue_valid;
  logic           queue_pop;
  logic           accept;

  // An event is taken whenever the command queue has room.
  assign accept = push && !full;

  // Front end: decodes the event into a command.
  ucdc_front u_front (
    .action_i         (action_i),
    .request_type_i   (request_type_i),
    .request_code_i   (request_code_i),
    .request_value_i  (request_value_i),
    .request_length_i (request_length_i),
    .received_count_i (received_count_i),
    .cmd_o            (front_cmd)
  );

  // Command queue decouples decode from execution.
  ucdc_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .wr_cmd_i (front_cmd),
    .full_o   (full),
    .rd_en_i  (queue_pop),
    .valid_o  (queue_valid),
    .rd_cmd_o (queue_cmd)
  );

  // Back end: device state, ROM walk and the result register.
  ucdc_back #(
    .MAX_PACKET (MAX_PACKET)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (queue_valid),
    .cmd_i            (queue_cmd),
    .cmd_pop_o        (queue_pop),
    .pop              (pop),
    .empty            (empty),
    .reply_kind_o     (reply_kind_o),
    .data_byte_o      (data_byte_o),
    .last_of_run_o    (last_of_run_o),
    .echo_count_o     (echo_count_o),
    .device_address_o (device_address_o),
    .configured_o     (configured_o)
  );

endmodule

FILE: sv/ucdc_front.sv
// Classifies one device event into a command for the back end. SETUP
// requests are decoded here, and data requests are trimmed to wLength.
module ucdc_front (
  input  logic [2:0]     action_i,
  input  logic [7:0]     request_type_i,
  input  logic [7:0]     request_code_i,
  input  logic [15:0]    request_value_i,
  input  logic [15:0]    request_length_i,
  input  logic [9:0]     received_count_i,
  output ucdc_pkg::cmd_t cmd_o
);

  logic       is_data;
  logic [2:0] data_src;
  logic [6:0] full_len;
  logic [6:0] trim_len;

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = ucdc_pkg::OP_QUIET;
    cmd_o.kind     = ucdc_pkg::RK_NONE;
    is_data        = 1'b0;
    data_src       = ucdc_pkg::SRC_NONE;
    case (action_i)
      ucdc_pkg::ACT_BUS_RESET: begin
        cmd_o.op = ucdc_pkg::OP_RESET;
      end
      ucdc_pkg::ACT_SETUP: begin
        cmd_o.op   = ucdc_pkg::OP_REPLY;
        cmd_o.kind = ucdc_pkg::RK_ZLP;
        if (request_type_i == ucdc_pkg::RT_STD_IN_DEV &&
            request_code_i == ucdc_pkg::RQ_GET_DESC) begin
          if (request_value_i[15:8] == ucdc_pkg::DESC_DEVICE) begin
            is_data  = 1'b1;
            data_src = ucdc_pkg::SRC_DEVICE;
          end else if (request_value_i[15:8] == ucdc_pkg::DESC_CONFIG) begin
            is_data  = 1'b1;
            data_src = ucdc_pkg::SRC_CONFIG;
          end else if (request_value_i[15:8] == ucdc_pkg::DESC_STRING &&
                       request_value_i[7:0] <= ucdc_pkg::LAST_STRING) begin
            is_data  = 1'b1;
            data_src = 3'(ucdc_pkg::SRC_LANG + request_value_i[2:0]);
          end else begin
            cmd_o.kind = ucdc_pkg::RK_STALL_IN;
          end
        end else if (request_type_i == ucdc_pkg::RT_STD_OUT_DEV &&
                     request_code_i == ucdc_pkg::RQ_SET_ADDRESS) begin
          cmd_o.set_addr = 1'b1;
          cmd_o.arg      = request_value_i[6:0];
        end else if (request_type_i == ucdc_pkg::RT_STD_OUT_DEV &&
                     request_code_i == ucdc_pkg::RQ_SET_CONFIG) begin
          cmd_o.set_cfg = 1'b1;
        end else if (request_type_i == ucdc_pkg::RT_STD_OUT_IF &&
                     request_code_i == ucdc_pkg::RQ_SET_IFACE) begin
          cmd_o.kind = ucdc_pkg::RK_ZLP;
        end else if (request_type_i == ucdc_pkg::RT_CLASS_IN_IF &&
                     request_code_i == ucdc_pkg::RQ_GET_LINE) begin
          is_data  = 1'b1;
          data_src = ucdc_pkg::SRC_LINE;
        end else if (request_type_i == ucdc_pkg::RT_CLASS_OUT_IF &&
                     (request_code_i == ucdc_pkg::RQ_SET_LINE ||
                      request_code_i == ucdc_pkg::RQ_SET_CTRL)) begin
          cmd_o.kind = ucdc_pkg::RK_ZLP;
        end else begin
          cmd_o.kind = ucdc_pkg::RK_STALL_BOTH;
        end
      end
      ucdc_pkg::ACT_EP0_IN_DONE: begin
        cmd_o.op = ucdc_pkg::OP_IN_DONE;
      end
      ucdc_pkg::ACT_EP1_OUT: begin
        if (received_count_i != 10'd0 && received_count_i <= ucdc_pkg::ECHO_MAX) begin
          cmd_o.op   = ucdc_pkg::OP_ECHO;
          cmd_o.kind = ucdc_pkg::RK_ECHO;
          cmd_o.arg  = received_count_i[6:0];
        end
      end
      default: begin
        cmd_o.op = ucdc_pkg::OP_QUIET;
      end
    endcase

    full_len = ucdc_pkg::rom_len(data_src);
    if ({9'd0, full_len} > request_length_i) begin
      trim_len = request_length_i[6:0];
    end else begin
      trim_len = full_len;
    end
    // A data request trimmed to nothing answers with a zero-length packet.
    if (is_data && trim_len != 7'd0) begin
      cmd_o.op  = ucdc_pkg::OP_START;
      cmd_o.src = data_src;
      cmd_o.arg = trim_len;
    end
  end

endmodule

FILE: sv/ucdc_cmd_fifo.sv
// Short command queue between the front and back ends.
module ucdc_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  ucdc_pkg::cmd_t wr_cmd_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output ucdc_pkg::cmd_t rd_cmd_o
);

  ucdc_pkg::cmd_t                  slots_q [ucdc_pkg::CmdDepth];
  logic [ucdc_pkg::CmdPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ucdc_pkg::CmdPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ucdc_pkg::CmdCntW-1:0]    count_q, count_d;

  assign full_o   = (count_q == ucdc_pkg::CmdCntW'(ucdc_pkg::CmdDepth));
  assign valid_o  = (count_q != '0);
  assign rd_cmd_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = ucdc_pkg::CmdPtrW'(wr_ptr_q + 1'b1);
    end
    if (rd_en_i) begin
      rd_ptr_d = ucdc_pkg::CmdPtrW'(rd_ptr_q + 1'b1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = ucdc_pkg::CmdCntW'(count_q + 1'b1);
    end else if (rd_en_i && !wr_en_i) begin
      count_d = ucdc_pkg::CmdCntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

FILE: sv/ucdc_back.sv
// Executes commands: holds the device state, walks the descriptor ROM for
// data transfers and drives the result register.
module ucdc_back #(
  parameter int MAX_PACKET = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ucdc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop,
  output logic           empty,
  output logic [2:0]     reply_kind_o,
  output logic [7:0]     data_byte_o,
  output logic           last_of_run_o,
  output logic [6:0]     echo_count_o,
  output logic [6:0]     device_address_o,
  output logic           configured_o
);

  localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);

  ucdc_pkg::back_state_e state_q, state_d;
  logic [6:0] pend_addr_q, pend_addr_d;
  logic [6:0] act_addr_q, act_addr_d;
  logic [2:0] src_q, src_d;
  logic [6:0] total_q, total_d;
  logic [6:0] sent_q, sent_d;
  logic       cfg_q, cfg_d;
  logic [6:0] idx_q, idx_d;
  logic [6:0] end_q, end_d;

  logic       out_valid_q, out_valid_d;
  logic [2:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [6:0] out_echo_q, out_echo_d;
  logic [6:0] out_addr_q, out_addr_d;
  logic       out_cfg_q, out_cfg_d;

  logic       out_free;
  logic       load;
  logic [6:0] chunk_base;
  logic [6:0] chunk_total;
  logic [6:0] chunk_rem;
  logic [6:0] chunk_len;
  logic [6:0] chunk_end;
  logic [6:0] idx_next;

  assign out_free = !out_valid_q || pop;
  assign idx_next = 7'(idx_q + 7'd1);

  // Next chunk boundary, from the start of a new transfer or from the
  // bytes already sent of the running one.
  always_comb begin
    if (cmd_i.op == ucdc_pkg::OP_START) begin
      chunk_base  = 7'd0;
      chunk_total = cmd_i.arg;
    end else begin
      chunk_base  = sent_q;
      chunk_total = total_q;
    end
    chunk_rem = 7'(chunk_total - chunk_base);
    chunk_len = (chunk_rem > MaxPkt) ? MaxPkt : chunk_rem;
    chunk_end = 7'(chunk_base + chunk_len);
  end

  always_comb begin
    state_d     = state_q;
    pend_addr_d = pend_addr_q;
    act_addr_d  = act_addr_q;
    src_d       = src_q;
    total_d     = total_q;
    sent_d      = sent_q;
    cfg_d       = cfg_q;
    idx_d       = idx_q;
    end_d       = end_q;
    cmd_pop_o   = 1'b0;
    load        = 1'b0;
    out_kind_d  = ucdc_pkg::RK_NONE;
    out_byte_d  = 8'h00;
    out_last_d  = 1'b1;
    out_echo_d  = 7'd0;

    case (state_q)
      ucdc_pkg::ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            ucdc_pkg::OP_RESET: begin
              pend_addr_d = 7'd0;
              act_addr_d  = 7'd0;
              cfg_d       = 1'b0;
              src_d       = ucdc_pkg::SRC_NONE;
              total_d     = 7'd0;
              sent_d      = 7'd0;
              load        = 1'b1;
            end
            ucdc_pkg::OP_REPLY: begin
              src_d   = ucdc_pkg::SRC_NONE;
              total_d = 7'd0;
              sent_d  = 7'd0;
              if (cmd_i.set_addr) begin
                pend_addr_d = cmd_i.arg;
              end
              if (cmd_i.set_cfg) begin
                cfg_d = 1'b1;
              end
              out_kind_d = cmd_i.kind;
              load       = 1'b1;
            end
            ucdc_pkg::OP_START: begin
              src_d   = cmd_i.src;
              total_d = cmd_i.arg;
              sent_d  = chunk_end;
              idx_d   = 7'd0;
              end_d   = chunk_end;
              state_d = ucdc_pkg::ST_SEND;
            end
            ucdc_pkg::OP_IN_DONE: begin
              if (pend_addr_q != 7'd0) begin
                act_addr_d  = pend_addr_q;
                pend_addr_d = 7'd0;
              end
              if (src_q != ucdc_pkg::SRC_NONE && sent_q < total_q) begin
                sent_d  = chunk_end;
                idx_d   = sent_q;
                end_d   = chunk_end;
                state_d = ucdc_pkg::ST_SEND;
              end else begin
                load = 1'b1;
              end
            end
            ucdc_pkg::OP_ECHO: begin
              out_kind_d = ucdc_pkg::RK_ECHO;
              out_echo_d = cmd_i.arg;
              load       = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ucdc_pkg::ST_SEND: begin
        if (out_free) begin
          load       = 1'b1;
          out_kind_d = ucdc_pkg::RK_DATA;
          out_byte_d = ucdc_pkg::rom_byte(src_q, idx_q);
          out_last_d = (idx_next == end_q);
          idx_d      = idx_next;
          if (idx_next == end_q) begin
            state_d = ucdc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ucdc_pkg::ST_IDLE;
      end
    endcase

    out_addr_d = act_addr_d;
    out_cfg_d  = cfg_d;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucdc_pkg::ST_IDLE;
      pend_addr_q <= 7'd0;
      act_addr_q  <= 7'd0;
      src_q       <= ucdc_pkg::SRC_NONE;
      total_q     <= 7'd0;
      sent_q      <= 7'd0;
      cfg_q       <= 1'b0;
      idx_q       <= 7'd0;
      end_q       <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_addr_q <= pend_addr_d;
      act_addr_q  <= act_addr_d;
      src_q       <= src_d;
      total_q     <= total_d;
      sent_q      <= sent_d;
      cfg_q       <= cfg_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= out_kind_d;
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_echo_q <= out_echo_d;
      out_addr_q <= out_addr_d;
      out_cfg_q  <= out_cfg_d;
    end
  end

  assign empty            = !out_valid_q;
  assign reply_kind_o     = out_kind_q;
  assign data_byte_o      = out_byte_q;
  assign last_of_run_o    = out_last_q;
  assign echo_count_o     = out_echo_q;
  assign device_address_o = out_addr_q;
  assign configured_o     = out_cfg_q;

endmodule

FILE: test/usb_cdc_control_responder_tb.sv
module usb_cdc_control_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_PACKET   = 64;
  // The slowest correct run is far below this: about 280 events, each at most
  // 64 results, each result waiting out a short random stall.
  localparam int LIMIT_CYCLES = 600000;
  // Longest stretch of work inside the block: a 64-byte chunk, while two events
  // can sit in its command queue.
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;

  // Action codes that the package leaves unnamed; the block must treat both as
  // quiet events.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef enum int {
    PH_STEADY,
    PH_TX_SLOW,
    PH_RX_SLOW,
    PH_BOTH_SLOW,
    PH_BACKPRESSURE
  } test_phase_e;

  // One device event as it is presented on the input side.
  typedef struct {
    logic [2:0]  action;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] rvalue;
    logic [15:0] rlength;
    logic [9:0]  rcount;
  } usb_event_t;

  // One reply as it should appear on the output side.
  typedef struct {
    ucdc_pkg::reply_kind_e kind;
    logic [7:0]  data;
    logic        last;
    logic [6:0]  echo;
    logic [6:0]  addr;
    logic        cfg;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  action_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_code_i = '0;
  logic [15:0] request_value_i = '0;
  logic [15:0] request_length_i = '0;
  logic [9:0]  received_count_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  reply_kind_o;
  logic [7:0]  data_byte_o;
  logic        last_of_run_o;
  logic [6:0]  echo_count_o;
  logic [6:0]  device_address_o;
  logic        configured_o;

  usb_cdc_control_responder #(
    .MAX_PACKET(MAX_PACKET)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .request_type_i  (request_type_i),
    .request_code_i  (request_code_i),
    .request_value_i (request_value_i),
    .request_length_i(request_length_i),
    .received_count_i(received_count_i),
    .empty           (empty),
    .pop             (pop),
    .reply_kind_o    (reply_kind_o),
    .data_byte_o     (data_byte_o),
    .last_of_run_o   (last_of_run_o),
    .echo_count_o    (echo_count_o),
    .device_address_o(device_address_o),
    .configured_o    (configured_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stimulus and pacing state. The stimulus process only changes these right
  // after a rising edge, and the driver and receiver only read them at the
  // falling edge, so there is no ordering race between the processes.
  usb_event_t  pending_events[$];
  usb_event_t  offered_event;
  bit          offer_taken = 1'b0;
  test_phase_e phase = PH_STEADY;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold = 1'b0;
  int          errors = 0;
  int          cycle_count = 0;

  // Descriptor ROM, all sources back to back: device (18 bytes), configuration
  // (67), language list (4), manufacturer string (18), product string (18) and
  // line coding (7).
  logic [7:0] desc_rom [132] = '{
    8'd18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'd64, 8'hFE,
    8'hCA, 8'h01, 8'h40, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
    8'd9, 8'h02, 8'd67, 8'd0, 8'd2, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'h04, 8'd0, 8'd0, 8'd1, 8'h02, 8'h02, 8'h01, 8'd0,
    8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
    8'd5, 8'h24, 8'h01, 8'h00, 8'h01,
    8'd4, 8'h24, 8'h02, 8'h02,
    8'd5, 8'h24, 8'h06, 8'h00, 8'h01,
    8'd7, 8'h05, 8'h82, 8'h03, 8'd8, 8'd0, 8'd255,
    8'd9, 8'h04, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'h00, 8'd0,
    8'd7, 8'h05, 8'h01, 8'h02, 8'd64, 8'd0, 8'd0,
    8'd7, 8'h05, 8'h81, 8'h02, 8'd64, 8'd0, 8'd0,
    8'd4, 8'h03, 8'h09, 8'h04,
    8'd18, 8'h03, 8'h42, 8'h00, 8'h65, 8'h00, 8'h65, 8'h00, 8'h42,
    8'h00, 8'h6F, 8'h00, 8'h74, 8'h00, 8'h69, 8'h00, 8'h78, 8'h00,
    8'd18, 8'h03, 8'h42, 8'h00, 8'h50, 8'h00, 8'h43, 8'h00, 8'h44,
    8'h00, 8'h43, 8'h00, 8'h20, 8'h00, 8'h76, 8'h00, 8'h31, 8'h00,
    8'h80, 8'h25, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
  };

  // Device state as the block should hold it.
  logic [6:0] held_addr = '0;
  logic [6:0] live_addr = '0;
  logic [2:0] reply_src = ucdc_pkg::SRC_NONE;
  logic [6:0] reply_total = '0;
  logic [6:0] reply_sent = '0;
  logic       dev_configured = 1'b0;

  reply_t step_replies[$];      // replies of the event being worked out
  reply_t expected_replies[$];  // replies still owed by the block, oldest first

  function automatic int desc_base(input logic [2:0] src);
    case (src)
      ucdc_pkg::SRC_DEVICE: return 0;
      ucdc_pkg::SRC_CONFIG: return 18;
      ucdc_pkg::SRC_LANG:   return 85;
      ucdc_pkg::SRC_MFR:    return 89;
      ucdc_pkg::SRC_PROD:   return 107;
      default:              return 125;
    endcase
  endfunction

  function automatic int desc_len(input logic [2:0] src);
    case (src)
      ucdc_pkg::SRC_DEVICE: return 18;
      ucdc_pkg::SRC_CONFIG: return 67;
      ucdc_pkg::SRC_LANG:   return 4;
      ucdc_pkg::SRC_MFR:    return 18;
      ucdc_pkg::SRC_PROD:   return 18;
      ucdc_pkg::SRC_LINE:   return 7;
      default:              return 0;
    endcase
  endfunction

  task automatic add_reply(input ucdc_pkg::reply_kind_e kind, input logic [7:0] data,
                           input logic [6:0] echo);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.echo = echo;
    r.last = 1'b0;
    r.addr = '0;
    r.cfg  = 1'b0;
    step_replies.push_back(r);
  endtask

  task automatic drop_reply();
    reply_src   = ucdc_pkg::SRC_NONE;
    reply_total = '0;
    reply_sent  = '0;
  endtask

  // Emit the next packet of the descriptor reply in progress, one result per
  // byte, at most MAX_PACKET bytes.
  task automatic send_next_chunk();
    int left;
    int chunk;
    if (reply_src == ucdc_pkg::SRC_NONE || reply_src > ucdc_pkg::SRC_LINE ||
        reply_sent >= reply_total) return;
    left  = int'(reply_total) - int'(reply_sent);
    chunk = (left > MAX_PACKET) ? MAX_PACKET : left;
    for (int i = 0; i < chunk; i++) begin
      add_reply(ucdc_pkg::RK_DATA,
                desc_rom[8'(desc_base(reply_src) + int'(reply_sent) + i)], 7'd0);
    end
    reply_sent = 7'(reply_sent + 7'(chunk));
  endtask

  // A data request is trimmed to wLength; when nothing is left the host gets
  // a zero-length packet instead of data.
  task automatic begin_reply(input logic [2:0] src, input logic [15:0] wlen);
    int len;
    len = desc_len(src);
    if (len > int'(wlen)) len = int'(wlen);
    reply_src   = src;
    reply_total = 7'(len);
    reply_sent  = '0;
    if (len == 0) begin
      drop_reply();
      add_reply(ucdc_pkg::RK_ZLP, 8'h00, 7'd0);
    end else begin
      send_next_chunk();
    end
  endtask

  task automatic answer_setup(input usb_event_t ev);
    logic [7:0] dtype;
    logic [7:0] dindex;
    dtype  = ev.rvalue[15:8];
    dindex = ev.rvalue[7:0];
    // Any new request abandons a reply that was still being sent.
    drop_reply();
    if (ev.rtype == ucdc_pkg::RT_STD_IN_DEV && ev.rcode == ucdc_pkg::RQ_GET_DESC) begin
      if (dtype == ucdc_pkg::DESC_DEVICE) begin
        begin_reply(ucdc_pkg::SRC_DEVICE, ev.rlength);
      end else if (dtype == ucdc_pkg::DESC_CONFIG) begin
        begin_reply(ucdc_pkg::SRC_CONFIG, ev.rlength);
      end else if (dtype == ucdc_pkg::DESC_STRING && dindex <= ucdc_pkg::LAST_STRING) begin
        begin_reply(3'(ucdc_pkg::SRC_LANG + dindex[2:0]), ev.rlength);
      end else begin
        // Unknown descriptor type or string index stalls only the IN side.
        add_reply(ucdc_pkg::RK_STALL_IN, 8'h00, 7'd0);
      end
    end else if (ev.rtype == ucdc_pkg::RT_STD_OUT_DEV &&
                 ev.rcode == ucdc_pkg::RQ_SET_ADDRESS) begin
      // The address only takes effect after the status stage.
      held_addr = ev.rvalue[6:0];
      add_reply(ucdc_pkg::RK_ZLP, 8'h00, 7'd0);
    end else if (ev.rtype == ucdc_pkg::RT_STD_OUT_DEV &&
                 ev.rcode == ucdc_pkg::RQ_SET_CONFIG) begin
      dev_configured = 1'b1;
      add_reply(ucdc_pkg::RK_ZLP, 8'h00, 7'd0);
    end else if (ev.rtype == ucdc_pkg::RT_STD_OUT_IF &&
                 ev.rcode == ucdc_pkg::RQ_SET_IFACE) begin
      add_reply(ucdc_pkg::RK_ZLP, 8'h00, 7'd0);
    end else if (ev.rtype == ucdc_pkg::RT_CLASS_IN_IF &&
                 ev.rcode == ucdc_pkg::RQ_GET_LINE) begin
      begin_reply(ucdc_pkg::SRC_LINE, ev.rlength);
    end else if (ev.rtype == ucdc_pkg::RT_CLASS_OUT_IF &&
                 (ev.rcode == ucdc_pkg::RQ_SET_LINE || ev.rcode == ucdc_pkg::RQ_SET_CTRL)) begin
      add_reply(ucdc_pkg::RK_ZLP, 8'h00, 7'd0);
    end else begin
      add_reply(ucdc_pkg::RK_STALL_BOTH, 8'h00, 7'd0);
    end
  endtask

  // Work out every reply that one accepted event causes and append them to
  // the expected stream.
  task automatic predict_event(input usb_event_t ev);
    reply_t r;
    case (ev.action)
      ucdc_pkg::ACT_BUS_RESET: begin
        held_addr      = '0;
        live_addr      = '0;
        dev_configured = 1'b0;
        drop_reply();
      end
      ucdc_pkg::ACT_SETUP: answer_setup(ev);
      ucdc_pkg::ACT_EP0_IN_DONE: begin
        // A pending address of zero leaves the active address alone.
        if (held_addr != 7'd0) begin
          live_addr = held_addr;
          held_addr = '0;
        end
        send_next_chunk();
      end
      ucdc_pkg::ACT_EP1_OUT: begin
        if (ev.rcount != 10'd0 && ev.rcount <= ucdc_pkg::ECHO_MAX) begin
          add_reply(ucdc_pkg::RK_ECHO, 8'h00, ev.rcount[6:0]);
        end
      end
      default: ;
    endcase
    // Every event gives at least one result; a silent one reports nothing.
    if (step_replies.size() == 0) add_reply(ucdc_pkg::RK_NONE, 8'h00, 7'd0);
    foreach (step_replies[i]) begin
      r = step_replies[i];
      r.last = (i == step_replies.size() - 1);
      r.addr = live_addr;
      r.cfg  = dev_configured;
      expected_replies.push_back(r);
    end
    step_replies.delete();
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Driver: a new event goes out at the falling edge once the previous offer
  // has been taken, unless the sender idles this cycle. An offer that the
  // block has not taken stays on the pins unchanged.
  always @(negedge clk_i) begin
    if (rst_ni && !(push && !offer_taken)) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
        offered_event = pending_events.pop_front();
        push             <= 1'b1;
        action_i         <= offered_event.action;
        request_type_i   <= offered_event.rtype;
        request_code_i   <= offered_event.rcode;
        request_value_i  <= offered_event.rvalue;
        request_length_i <= offered_event.rlength;
        received_count_i <= offered_event.rcount;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: pop is redecided every falling edge; during the long hold it
  // stays low so the block fills up and pushes back on the sender.
  always @(negedge clk_i) begin
    if (rst_ni) pop <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Monitor: at each rising edge, an accepted event is predicted first and an
  // accepted result is then checked against the oldest expectation.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (push && !full) begin
        predict_event(offered_event);
        offer_taken = 1'b1;
      end else begin
        offer_taken = 1'b0;
      end
      if (pop && !empty) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual kind %0d",
                   $time, reply_kind_o);
        end else begin
          want = expected_replies.pop_front();
          compare_field("reply_kind", 16'(want.kind), 16'(reply_kind_o));
          compare_field("data_byte", 16'(want.data), 16'(data_byte_o));
          compare_field("last_of_run", 16'(want.last), 16'(last_of_run_o));
          compare_field("echo_count", 16'(want.echo), 16'(echo_count_o));
          compare_field("device_address", 16'(want.addr), 16'(device_address_o));
          compare_field("configured", 16'(want.cfg), 16'(configured_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The long receiver hold-off runs in its own process and counts its cycles.
  initial begin
    wait (phase == PH_BACKPRESSURE);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic usb_event_t random_event(input logic [2:0] action);
    usb_event_t ev;
    // Fields that the action does not use still carry random values.
    ev.action  = action;
    ev.rtype   = 8'($urandom);
    ev.rcode   = 8'($urandom);
    ev.rvalue  = 16'($urandom);
    ev.rlength = 16'($urandom);
    ev.rcount  = 10'($urandom);
    return ev;
  endfunction

  task automatic queue_setup(input logic [7:0] rtype, input logic [7:0] rcode,
                             input logic [15:0] rvalue, input logic [15:0] rlength);
    usb_event_t ev;
    ev = '{ucdc_pkg::ACT_SETUP, rtype, rcode, rvalue, rlength, 10'd0};
    pending_events.push_back(ev);
  endtask

  task automatic queue_action(input logic [2:0] action, input logic [9:0] rcount);
    usb_event_t ev;
    ev = '{action, 8'h00, 8'h00, 16'h0000, 16'h0000, rcount};
    pending_events.push_back(ev);
  endtask

  function automatic logic [15:0] random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 16'h0000;
    if (pick < 18) return 16'hFFFF;
    if (pick < 70) return 16'($urandom_range(1, 80));
    return 16'($urandom);
  endfunction

  // One burst of random traffic. Most bursts are complete control sequences
  // (request, data stages, status stage) with random contents; the rest are
  // lone events and raw noise.
  task automatic queue_random_burst();
    usb_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    ev = random_event(ucdc_pkg::ACT_SETUP);
    ev.rlength = random_length();
    if (pick < 35) begin
      ev.rtype = ucdc_pkg::RT_STD_IN_DEV;
      ev.rcode = ucdc_pkg::RQ_GET_DESC;
      case ($urandom_range(0, 5))
        0: ev.rvalue[15:8] = ucdc_pkg::DESC_DEVICE;
        1: ev.rvalue[15:8] = ucdc_pkg::DESC_CONFIG;
        2: ev.rvalue = {ucdc_pkg::DESC_STRING, 8'($urandom_range(0, 2))};
        3: ev.rvalue[15:8] = ucdc_pkg::DESC_STRING;
        4: begin
          ev.rtype = ucdc_pkg::RT_CLASS_IN_IF;
          ev.rcode = ucdc_pkg::RQ_GET_LINE;
        end
        default: ;
      endcase
      pending_events.push_back(ev);
      // Zero IN completions here means the next request cuts the reply short.
      repeat ($urandom_range(0, 3)) begin
        pending_events.push_back(random_event(ucdc_pkg::ACT_EP0_IN_DONE));
      end
      if ($urandom_range(0, 1) == 1) begin
        pending_events.push_back(random_event(ucdc_pkg::ACT_EP0_OUT_DONE));
      end
    end else if (pick < 47) begin
      ev.rtype = ucdc_pkg::RT_STD_OUT_DEV;
      ev.rcode = ucdc_pkg::RQ_SET_ADDRESS;
      if ($urandom_range(0, 4) == 0) ev.rvalue[6:0] = 7'd0;
      pending_events.push_back(ev);
      pending_events.push_back(random_event(ucdc_pkg::ACT_EP0_IN_DONE));
    end else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0: begin
          ev.rtype = ucdc_pkg::RT_STD_OUT_DEV;
          ev.rcode = ucdc_pkg::RQ_SET_CONFIG;
        end
        1: begin
          ev.rtype = ucdc_pkg::RT_STD_OUT_IF;
          ev.rcode = ucdc_pkg::RQ_SET_IFACE;
        end
        2: begin
          ev.rtype = ucdc_pkg::RT_CLASS_OUT_IF;
          ev.rcode = ucdc_pkg::RQ_SET_LINE;
        end
        default: begin
          ev.rtype = ucdc_pkg::RT_CLASS_OUT_IF;
          ev.rcode = ucdc_pkg::RQ_SET_CTRL;
        end
      endcase
      pending_events.push_back(ev);
    end else if (pick < 72) begin
      ev = random_event(ucdc_pkg::ACT_EP1_OUT);
      case ($urandom_range(0, 3))
        0: ev.rcount = 10'd0;
        1: ev.rcount = 10'($urandom_range(65, 1023));
        default: ev.rcount = 10'($urandom_range(1, 64));
      endcase
      pending_events.push_back(ev);
    end else if (pick < 77) begin
      pending_events.push_back(random_event(ucdc_pkg::ACT_BUS_RESET));
    end else if (pick < 87) begin
      case ($urandom_range(0, 4))
        0: pending_events.push_back(random_event(ucdc_pkg::ACT_EP0_IN_DONE));
        1: pending_events.push_back(random_event(ucdc_pkg::ACT_EP0_OUT_DONE));
        2: pending_events.push_back(random_event(ucdc_pkg::ACT_OTHER_IN_DONE));
        3: pending_events.push_back(random_event(ACT_SPARE_6));
        default: pending_events.push_back(random_event(ACT_SPARE_7));
      endcase
    end else begin
      // Noise: any action with random request bytes, half of them looking
      // like a standard device-to-host request.
      ev.action = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) ev.rtype = ucdc_pkg::RT_STD_IN_DEV;
      pending_events.push_back(ev);
    end
  endtask

  task automatic queue_random_events(input int target);
    int added;
    int prior;
    added = 0;
    while (added < target) begin
      prior = pending_events.size();
      queue_random_burst();
      added += pending_events.size() - prior;
    end
  endtask

  task automatic wait_all_offered();
    while (pending_events.size() != 0 || push) @(posedge clk_i);
  endtask

  task automatic enter_phase(input test_phase_e p, input int tx_pct, input int rx_pct);
    phase        = p;
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    enter_phase(PH_STEADY, 0, 0);
    // Directed part: descriptor reads past one packet, trimming, zero length,
    // every stall, address handling, configuration, class requests, the echo
    // limits and the quiet events.
    queue_action(ucdc_pkg::ACT_BUS_RESET, 10'd0);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC,
                {ucdc_pkg::DESC_DEVICE, 8'h00}, 16'hFFFF);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC,
                {ucdc_pkg::DESC_CONFIG, 8'h00}, 16'hFFFF);
    queue_action(ucdc_pkg::ACT_EP0_IN_DONE, 10'd0);
    queue_action(ucdc_pkg::ACT_EP0_IN_DONE, 10'd0);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC,
                {ucdc_pkg::DESC_STRING, ucdc_pkg::LAST_STRING}, 16'h00FF);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC,
                {ucdc_pkg::DESC_STRING, 8'h03}, 16'h0040);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC, 16'hFF00, 16'h0012);
    queue_setup(ucdc_pkg::RT_STD_IN_DEV, ucdc_pkg::RQ_GET_DESC,
                {ucdc_pkg::DESC_DEVICE, 8'hFF}, 16'h0000);
    queue_setup(ucdc_pkg::RT_STD_OUT_DEV, ucdc_pkg::RQ_SET_ADDRESS, 16'hFFFF, 16'h0000);
    queue_action(ucdc_pkg::ACT_EP0_IN_DONE, 10'd0);
    queue_setup(ucdc_pkg::RT_STD_OUT_DEV, ucdc_pkg::RQ_SET_ADDRESS, 16'hFF80, 16'h0000);
    queue_action(ucdc_pkg::ACT_EP0_IN_DONE, 10'd0);
    queue_setup(ucdc_pkg::RT_STD_OUT_DEV, ucdc_pkg::RQ_SET_CONFIG, 16'h0000, 16'h0000);
    queue_setup(ucdc_pkg::RT_STD_OUT_IF, ucdc_pkg::RQ_SET_IFACE, 16'h0001, 16'h0000);
    queue_setup(ucdc_pkg::RT_CLASS_IN_IF, ucdc_pkg::RQ_GET_LINE, 16'h0000, 16'hFFFF);
    queue_setup(ucdc_pkg::RT_CLASS_OUT_IF, ucdc_pkg::RQ_SET_LINE, 16'h0000, 16'h0007);
    queue_setup(ucdc_pkg::RT_CLASS_OUT_IF, ucdc_pkg::RQ_SET_CTRL, 16'h0003, 16'h0000);
    queue_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_action(ucdc_pkg::ACT_EP1_OUT, 10'd0);
    queue_action(ucdc_pkg::ACT_EP1_OUT, 10'd64);
    queue_action(ucdc_pkg::ACT_EP1_OUT, 10'h3FF);
    queue_action(ucdc_pkg::ACT_EP0_OUT_DONE, 10'd0);
    queue_action(ACT_SPARE_7, 10'd0);
    queue_action(ucdc_pkg::ACT_BUS_RESET, 10'd0);
    queue_random_events(55);
    wait_all_offered();

    enter_phase(PH_TX_SLOW, 71, 0);
    queue_random_events(55);
    wait_all_offered();

    enter_phase(PH_RX_SLOW, 0, 71);
    queue_random_events(55);
    wait_all_offered();

    enter_phase(PH_BOTH_SLOW, 20, 20);
    queue_random_events(55);
    wait_all_offered();

    // Back-to-back events while the receiver holds off for a long stretch.
    enter_phase(PH_BACKPRESSURE, 0, 0);
    queue_random_events(25);
    wait_all_offered();

    while (expected_replies.size() != 0) @(posedge clk_i);
    // Give a misbehaving block room to emit stray results.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: usb_cdc_control_responder.f
sv/ucdc_pkg.sv
sv/ucdc_front.sv
sv/ucdc_cmd_fifo.sv
sv/ucdc_back.sv
sv/usb_cdc_control_responder.sv
test/usb_cdc_control_responder_tb.sv
